// ----- hdl/ct2d_pkg.sv -----
// Shared types and constants for the 2D collision tester pipeline.
`timescale 1ns / 1ps

package ct2d_pkg;

    // Default coordinate width (Q15.8 words).
    localparam int COORD_BITS = 24;

    // Pair selector codes.
    localparam logic [2:0] CMD_BOX_BOX       = 3'd0;
    localparam logic [2:0] CMD_CIRCLE_CIRCLE = 3'd1;
    localparam logic [2:0] CMD_BOX_CIRCLE    = 3'd2;
    localparam logic [2:0] CMD_CIRCLE_BOX    = 3'd3;
    localparam logic [2:0] CMD_POINT_BOX     = 3'd4;
    localparam logic [2:0] CMD_POINT_CIRCLE  = 3'd5;

    // Kind of test an item needs after operand selection.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BOX,
        KIND_DIST
    } ct2d_kind_t;

    // Control that travels down the pipeline with each word.
    typedef struct packed {
        logic       valid;
        ct2d_kind_t kind;
        logic       box_hit;
    } ct2d_ctl_t;

endpackage

// ----- hdl/ct2d_select.sv -----
// Stage one: decode the pair selector, pick the two boxes and the radius, form box edges.
`timescale 1ns / 1ps

module ct2d_select #(
    parameter int COORD_BITS = ct2d_pkg::COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   cmd,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-2:0]        a_ext_x,
    input  logic [COORD_BITS-2:0]        a_ext_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic [COORD_BITS-2:0]        b_ext_x,
    input  logic [COORD_BITS-2:0]        b_ext_y,
    input  logic                         out_ready,
    output ct2d_pkg::ct2d_ctl_t          out_ctl,
    output logic signed [COORD_BITS-1:0] f_lo_x,
    output logic signed [COORD_BITS-1:0] f_lo_y,
    output logic signed [COORD_BITS:0]   f_hi_x,
    output logic signed [COORD_BITS:0]   f_hi_y,
    output logic signed [COORD_BITS-1:0] s_lo_x,
    output logic signed [COORD_BITS-1:0] s_lo_y,
    output logic signed [COORD_BITS:0]   s_hi_x,
    output logic signed [COORD_BITS:0]   s_hi_y,
    output logic [COORD_BITS-1:0]        radius
);

    localparam int C = COORD_BITS;

    ct2d_pkg::ct2d_ctl_t   ctl_reg;
    ct2d_pkg::ct2d_kind_t  kind_next;
    logic signed [C-1:0]   fx_next, fy_next, sx_next, sy_next;
    logic [C-2:0]          fw_next, fh_next, sw_next, sh_next;
    logic [C-1:0]          r_next;
    logic signed [C-1:0]   f_lo_x_reg, f_lo_y_reg, s_lo_x_reg, s_lo_y_reg;
    logic signed [C:0]     f_hi_x_reg, f_hi_y_reg, s_hi_x_reg, s_hi_y_reg;
    logic [C-1:0]          radius_reg;

    assign in_ready = !ctl_reg.valid || out_ready;

    // Map every pair onto a first box and a second box. A circle centre or a point
    // becomes a box of zero size, so one clamp and one overlap test serve all pairs.
    always_comb
    begin
        kind_next = ct2d_pkg::KIND_DIST;
        fx_next   = a_x;
        fy_next   = a_y;
        fw_next   = '0;
        fh_next   = '0;
        sx_next   = b_x;
        sy_next   = b_y;
        sw_next   = b_ext_x;
        sh_next   = b_ext_y;
        r_next    = '0;
        unique case (cmd)
            ct2d_pkg::CMD_BOX_BOX:
            begin
                kind_next = ct2d_pkg::KIND_BOX;
                fw_next   = a_ext_x;
                fh_next   = a_ext_y;
            end
            ct2d_pkg::CMD_POINT_BOX:
            begin
                kind_next = ct2d_pkg::KIND_BOX;
            end
            ct2d_pkg::CMD_CIRCLE_CIRCLE:
            begin
                sw_next = '0;
                sh_next = '0;
                r_next  = {1'b0, a_ext_x} + {1'b0, b_ext_x};
            end
            ct2d_pkg::CMD_BOX_CIRCLE:
            begin
                fx_next = b_x;
                fy_next = b_y;
                sx_next = a_x;
                sy_next = a_y;
                sw_next = a_ext_x;
                sh_next = a_ext_y;
                r_next  = {1'b0, b_ext_x};
            end
            ct2d_pkg::CMD_CIRCLE_BOX:
            begin
                r_next = {1'b0, a_ext_x};
            end
            ct2d_pkg::CMD_POINT_CIRCLE:
            begin
                sw_next = '0;
                sh_next = '0;
                r_next  = {1'b0, b_ext_x};
            end
            default:
            begin
                kind_next = ct2d_pkg::KIND_NONE;
            end
        endcase
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg.valid   <= in_valid;
            ctl_reg.kind    <= kind_next;
            ctl_reg.box_hit <= 1'b0;
        end
    end

    // Operand registers with the far edges of both boxes.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            f_lo_x_reg <= fx_next;
            f_lo_y_reg <= fy_next;
            s_lo_x_reg <= sx_next;
            s_lo_y_reg <= sy_next;
            f_hi_x_reg <= (C+1)'(fx_next) + $signed({2'b00, fw_next});
            f_hi_y_reg <= (C+1)'(fy_next) + $signed({2'b00, fh_next});
            s_hi_x_reg <= (C+1)'(sx_next) + $signed({2'b00, sw_next});
            s_hi_y_reg <= (C+1)'(sy_next) + $signed({2'b00, sh_next});
            radius_reg <= r_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign f_lo_x  = f_lo_x_reg;
    assign f_lo_y  = f_lo_y_reg;
    assign f_hi_x  = f_hi_x_reg;
    assign f_hi_y  = f_hi_y_reg;
    assign s_lo_x  = s_lo_x_reg;
    assign s_lo_y  = s_lo_y_reg;
    assign s_hi_x  = s_hi_x_reg;
    assign s_hi_y  = s_hi_y_reg;
    assign radius  = radius_reg;

endmodule

// ----- hdl/ct2d_clamp.sv -----
// Stage two: box overlap test and clamped distance from the first box to the second.
`timescale 1ns / 1ps

module ct2d_clamp #(
    parameter int COORD_BITS = ct2d_pkg::COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ct2d_pkg::ct2d_ctl_t          in_ctl,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] f_lo_x,
    input  logic signed [COORD_BITS-1:0] f_lo_y,
    input  logic signed [COORD_BITS:0]   f_hi_x,
    input  logic signed [COORD_BITS:0]   f_hi_y,
    input  logic signed [COORD_BITS-1:0] s_lo_x,
    input  logic signed [COORD_BITS-1:0] s_lo_y,
    input  logic signed [COORD_BITS:0]   s_hi_x,
    input  logic signed [COORD_BITS:0]   s_hi_y,
    input  logic [COORD_BITS-1:0]        radius_in,
    input  logic                         out_ready,
    output ct2d_pkg::ct2d_ctl_t          out_ctl,
    output logic [COORD_BITS-1:0]        dist_x,
    output logic [COORD_BITS-1:0]        dist_y,
    output logic [COORD_BITS-1:0]        radius
);

    localparam int C = COORD_BITS;

    ct2d_pkg::ct2d_ctl_t ctl_reg;
    logic [C-1:0]        dist_x_reg, dist_y_reg, radius_reg;
    logic [C-1:0]        dist_x_next, dist_y_next;
    logic                hit_x, hit_y;

    // Distance from p to the span [lo, hi] on one axis; zero when p lies inside.
    // The result always fits in C bits unsigned.
    function automatic logic [C-1:0] axis_dist(input logic signed [C-1:0] p,
                                               input logic signed [C-1:0] lo,
                                               input logic signed [C:0]   hi);
        logic signed [C+1:0] below;
        logic signed [C+1:0] above;
        logic [C-1:0]        d;
        below = (C+2)'(lo) - (C+2)'(p);
        above = (C+2)'(p) - (C+2)'(hi);
        if (p < lo)
            d = below[C-1:0];
        else if ((C+1)'(p) > hi)
            d = above[C-1:0];
        else
            d = '0;
        return d;
    endfunction

    assign in_ready = !ctl_reg.valid || out_ready;

    // Boxes overlap unless one lies strictly beyond the other on some axis.
    assign hit_x = !((f_hi_x < (C+1)'(s_lo_x)) || (s_hi_x < (C+1)'(f_lo_x)));
    assign hit_y = !((f_hi_y < (C+1)'(s_lo_y)) || (s_hi_y < (C+1)'(f_lo_y)));

    assign dist_x_next = axis_dist(f_lo_x, s_lo_x, s_hi_x);
    assign dist_y_next = axis_dist(f_lo_y, s_lo_y, s_hi_y);

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg.valid   <= in_ctl.valid;
            ctl_reg.kind    <= in_ctl.kind;
            ctl_reg.box_hit <= hit_x && hit_y;
        end
    end

    // Distance registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            dist_x_reg <= dist_x_next;
            dist_y_reg <= dist_y_next;
            radius_reg <= radius_in;
        end
    end

    assign out_ctl = ctl_reg;
    assign dist_x  = dist_x_reg;
    assign dist_y  = dist_y_reg;
    assign radius  = radius_reg;

endmodule

// ----- hdl/ct2d_square.sv -----
// Stage three: squares of both axis distances and of the radius.
`timescale 1ns / 1ps

module ct2d_square #(
    parameter int COORD_BITS = ct2d_pkg::COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ct2d_pkg::ct2d_ctl_t           in_ctl,
    output logic                          in_ready,
    input  logic [COORD_BITS-1:0]         dist_x,
    input  logic [COORD_BITS-1:0]         dist_y,
    input  logic [COORD_BITS-1:0]         radius,
    input  logic                          out_ready,
    output ct2d_pkg::ct2d_ctl_t           out_ctl,
    output logic [2*COORD_BITS-1:0]       sq_x,
    output logic [2*COORD_BITS-1:0]       sq_y,
    output logic [2*COORD_BITS-1:0]       sq_r
);

    localparam int C = COORD_BITS;

    ct2d_pkg::ct2d_ctl_t ctl_reg;
    logic [2*C-1:0]      sq_x_reg, sq_y_reg, sq_r_reg;

    assign in_ready = !ctl_reg.valid || out_ready;

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg <= in_ctl;
        end
    end

    // Three independent multipliers, each registered.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            sq_x_reg <= (2*C)'(dist_x) * (2*C)'(dist_x);
            sq_y_reg <= (2*C)'(dist_y) * (2*C)'(dist_y);
            sq_r_reg <= (2*C)'(radius) * (2*C)'(radius);
        end
    end

    assign out_ctl = ctl_reg;
    assign sq_x    = sq_x_reg;
    assign sq_y    = sq_y_reg;
    assign sq_r    = sq_r_reg;

endmodule

// ----- hdl/collision_test_2d.sv -----
// Top level of the 2D collision tester: four-stage pipeline with the final compare.
// Throughput: one word per cycle while hit_ready is high.
// Every stage holds its own valid bit and fills bubbles.
// A stalled output stops only the stages behind it that are full; nothing is lost.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data is not reset.
`timescale 1ns / 1ps

module collision_test_2d #(
    parameter int COORD_BITS = ct2d_pkg::COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [2:0]                   cmd,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-2:0]        a_ext_x,
    input  logic [COORD_BITS-2:0]        a_ext_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic [COORD_BITS-2:0]        b_ext_x,
    input  logic [COORD_BITS-2:0]        b_ext_y,
    output logic                         hit_valid,
    input  logic                         hit_ready,
    output logic                         hit
);

    localparam int C = COORD_BITS;

    ct2d_pkg::ct2d_ctl_t sel_ctl, clp_ctl, sq_ctl;
    logic                sel_ready, clp_ready, sq_ready;
    logic signed [C-1:0] f_lo_x, f_lo_y, s_lo_x, s_lo_y;
    logic signed [C:0]   f_hi_x, f_hi_y, s_hi_x, s_hi_y;
    logic [C-1:0]        sel_radius, clp_radius, dist_x, dist_y;
    logic [2*C-1:0]      sq_x, sq_y, sq_r;
    logic [2*C:0]        dist_sq;
    logic                out_valid_reg, hit_reg, hit_next;

    ct2d_select #(
        .COORD_BITS (COORD_BITS)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .cmd       (cmd),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_ext_x   (a_ext_x),
        .a_ext_y   (a_ext_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_ext_x   (b_ext_x),
        .b_ext_y   (b_ext_y),
        .out_ready (sel_ready),
        .out_ctl   (sel_ctl),
        .f_lo_x    (f_lo_x),
        .f_lo_y    (f_lo_y),
        .f_hi_x    (f_hi_x),
        .f_hi_y    (f_hi_y),
        .s_lo_x    (s_lo_x),
        .s_lo_y    (s_lo_y),
        .s_hi_x    (s_hi_x),
        .s_hi_y    (s_hi_y),
        .radius    (sel_radius)
    );

    ct2d_clamp #(
        .COORD_BITS (COORD_BITS)
    ) u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sel_ctl),
        .in_ready  (sel_ready),
        .f_lo_x    (f_lo_x),
        .f_lo_y    (f_lo_y),
        .f_hi_x    (f_hi_x),
        .f_hi_y    (f_hi_y),
        .s_lo_x    (s_lo_x),
        .s_lo_y    (s_lo_y),
        .s_hi_x    (s_hi_x),
        .s_hi_y    (s_hi_y),
        .radius_in (sel_radius),
        .out_ready (clp_ready),
        .out_ctl   (clp_ctl),
        .dist_x    (dist_x),
        .dist_y    (dist_y),
        .radius    (clp_radius)
    );

    ct2d_square #(
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (clp_ctl),
        .in_ready  (clp_ready),
        .dist_x    (dist_x),
        .dist_y    (dist_y),
        .radius    (clp_radius),
        .out_ready (sq_ready),
        .out_ctl   (sq_ctl),
        .sq_x      (sq_x),
        .sq_y      (sq_y),
        .sq_r      (sq_r)
    );

    // Output stage takes a new word whenever it is empty or its word is being taken.
    assign sq_ready = !out_valid_reg || hit_ready;

    // Squared distance against squared radius, inclusive; box tests pass their flag.
    assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

    always_comb
    begin
        case (sq_ctl.kind)
            ct2d_pkg::KIND_DIST: hit_next = (dist_sq <= {1'b0, sq_r});
            ct2d_pkg::KIND_BOX:  hit_next = sq_ctl.box_hit;
            default:             hit_next = 1'b0;
        endcase
    end

    // Output valid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            out_valid_reg <= sq_ctl.valid;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (sq_ready && sq_ctl.valid)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

// ----- tb/collision_test_2d_tb.sv -----
// Self-checking testbench for the 2D collision tester: random and directed pair tests.
`timescale 1ns / 1ps

module collision_test_2d_tb;

    localparam int CB = ct2d_pkg::COORD_BITS;

    // Selectors that the block does not support.
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;
    localparam int EXT_MAX = 8388607;

    localparam int RANDOM_WORDS = 1430;
    localparam int WATCHDOG_LIMIT = 2000;

    // One pair test as the sender offers it, with its pacing.
    typedef struct {
        logic [2:0]             cmd;
        logic signed [CB-1:0]   ax;
        logic signed [CB-1:0]   ay;
        logic [CB-2:0]          aw;
        logic [CB-2:0]          ah;
        logic signed [CB-1:0]   bx;
        logic signed [CB-1:0]   by;
        logic [CB-2:0]          bw;
        logic [CB-2:0]          bh;
        int                     gap;
        bit                     drain;
    } pair_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    logic [2:0]             cmd;
    logic signed [CB-1:0]   a_x;
    logic signed [CB-1:0]   a_y;
    logic [CB-2:0]          a_ext_x;
    logic [CB-2:0]          a_ext_y;
    logic signed [CB-1:0]   b_x;
    logic signed [CB-1:0]   b_y;
    logic [CB-2:0]          b_ext_x;
    logic [CB-2:0]          b_ext_y;
    logic                   hit_valid;
    logic                   hit_ready;
    logic                   hit;

    pair_word_t pending_pairs[$];
    bit         expected_hits[$];

    pair_word_t staged;
    bit         staged_ok;
    int         gap_left;
    bit         in_accept;
    int         pairs_total;
    int         pairs_accepted;
    int         hits_seen;
    int         error_count;
    int         quiet_cycles;
    int         stall_left;
    bit         long_hold_done;
    int         ready_roll;

    collision_test_2d DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_ext_x    (a_ext_x),
        .a_ext_y    (a_ext_y),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_ext_x    (b_ext_x),
        .b_ext_y    (b_ext_y),
        .hit_valid  (hit_valid),
        .hit_ready  (hit_ready),
        .hit        (hit)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Absolute difference of two coordinates.
    function automatic longint unsigned span(longint p, longint q);
        return (p >= q) ? 64'(p - q) : 64'(q - p);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Squared distance against squared radius; all terms stay below 2^52.
    function automatic bit in_reach(longint unsigned dx, longint unsigned dy,
                                    longint unsigned r);
        return (dx * dx + dy * dy) <= (r * r);
    endfunction

    // The centre is pulled into the box and the gap is measured from there.
    function automatic bit circle_meets_box(longint bx, longint by, longint bw, longint bh,
                                            longint cx, longint cy, longint r);
        longint qx;
        longint qy;
        qx = clip(cx, bx, bx + bw);
        qy = clip(cy, by, by + bh);
        return in_reach(span(cx, qx), span(cy, qy), 64'(r));
    endfunction

    // Expected hit bit for one pair test.
    function automatic bit predict_hit(logic [2:0] sel,
                                       logic signed [CB-1:0] pax, logic signed [CB-1:0] pay,
                                       logic [CB-2:0] paw, logic [CB-2:0] pah,
                                       logic signed [CB-1:0] pbx, logic signed [CB-1:0] pby,
                                       logic [CB-2:0] pbw, logic [CB-2:0] pbh);
        longint ax;
        longint ay;
        longint aw;
        longint ah;
        longint bx;
        longint by;
        longint bw;
        longint bh;
        bit     res;
        ax = pax;
        ay = pay;
        aw = paw;
        ah = pah;
        bx = pbx;
        by = pby;
        bw = pbw;
        bh = pbh;
        case (sel)
            ct2d_pkg::CMD_BOX_BOX:
                res = !(ax + aw < bx || bx + bw < ax || ay + ah < by || by + bh < ay);
            ct2d_pkg::CMD_CIRCLE_CIRCLE:
                res = in_reach(span(ax, bx), span(ay, by), 64'(aw + bw));
            ct2d_pkg::CMD_BOX_CIRCLE:
                res = circle_meets_box(ax, ay, aw, ah, bx, by, bw);
            ct2d_pkg::CMD_CIRCLE_BOX:
                res = circle_meets_box(bx, by, bw, bh, ax, ay, aw);
            ct2d_pkg::CMD_POINT_BOX:
                res = ax >= bx && ax <= bx + bw && ay >= by && ay <= by + bh;
            ct2d_pkg::CMD_POINT_CIRCLE:
                res = in_reach(span(ax, bx), span(ay, by), 64'(bw));
            default:
                res = 1'b0;
        endcase
        return res;
    endfunction

    task automatic add_pair(logic [2:0] sel, int ax, int ay, int aw, int ah,
                            int bx, int by, int bw, int bh, int gap, bit drain);
        pair_word_t w;
        w.cmd = sel;
        w.ax = CB'(ax);
        w.ay = CB'(ay);
        w.aw = (CB-1)'(aw);
        w.ah = (CB-1)'(ah);
        w.bx = CB'(bx);
        w.by = CB'(by);
        w.bw = (CB-1)'(bw);
        w.bh = (CB-1)'(bh);
        w.gap = gap;
        w.drain = drain;
        pending_pairs.push_back(w);
    endtask

    // Random pair: mostly shapes clustered near one spot so that hits and near
    // misses are common, with some words of fully random bits.
    function automatic pair_word_t random_pair(int idx);
        pair_word_t w;
        int         mode;
        int         spread;
        int         cx;
        int         cy;
        int         r;
        if ($urandom_range(0, 15) == 0)
            w.cmd = 3'($urandom_range(6, 7));
        else
            w.cmd = 3'($urandom_range(0, 5));
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            w.ax = CB'($urandom);
            w.ay = CB'($urandom);
            w.bx = CB'($urandom);
            w.by = CB'($urandom);
            w.aw = (CB-1)'($urandom);
            w.ah = (CB-1)'($urandom);
            w.bw = (CB-1)'($urandom);
            w.bh = (CB-1)'($urandom);
        end
        else
        begin
            spread = (mode < 5) ? 64 : 4096;
            cx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            cy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            w.ax = CB'(cx + int'($urandom_range(0, 2 * spread)) - spread);
            w.ay = CB'(cy + int'($urandom_range(0, 2 * spread)) - spread);
            w.bx = CB'(cx + int'($urandom_range(0, 2 * spread)) - spread);
            w.by = CB'(cy + int'($urandom_range(0, 2 * spread)) - spread);
            w.aw = (CB-1)'($urandom_range(0, spread));
            w.ah = (CB-1)'($urandom_range(0, spread));
            w.bw = (CB-1)'($urandom_range(0, spread));
            w.bh = (CB-1)'($urandom_range(0, spread));
            if (mode == 1)
            begin
                w.aw = (CB-1)'($urandom);
                w.bh = (CB-1)'($urandom);
            end
        end
        // Back-to-back stretches carry the long receiver hold-off and a quiet run.
        r = $urandom_range(0, 99);
        if ((idx >= 360 && idx < 700) || (idx >= 900 && idx < 1000))
            w.gap = 0;
        else if (r < 60)
            w.gap = 0;
        else if (r < 92)
            w.gap = $urandom_range(1, 3);
        else
            w.gap = $urandom_range(10, 40);
        w.drain = (idx == 1100) || (idx >= 700 && $urandom_range(0, 199) == 0);
        return w;
    endfunction

    // Sender: offers queued words at the falling edge and holds each until taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(item_valid && !in_accept))
            begin
                if (!staged_ok && pending_pairs.size() != 0)
                begin
                    staged = pending_pairs.pop_front();
                    staged_ok = 1'b1;
                    gap_left = staged.gap;
                end
                if (staged_ok && gap_left == 0 &&
                    !(staged.drain && expected_hits.size() != 0))
                begin
                    cmd <= staged.cmd;
                    a_x <= staged.ax;
                    a_y <= staged.ay;
                    a_ext_x <= staged.aw;
                    a_ext_y <= staged.ah;
                    b_x <= staged.bx;
                    b_y <= staged.by;
                    b_ext_x <= staged.bw;
                    b_ext_y <= staged.bh;
                    item_valid <= 1'b1;
                    staged_ok = 1'b0;
                end
                else
                begin
                    item_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off and one stretch always ready.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && hits_seen >= 400)
            begin
                long_hold_done = 1'b1;
                stall_left = 300;
                hit_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                hit_ready <= 1'b0;
            end
            else if (hits_seen >= 800 && hits_seen < 1000)
            begin
                hit_ready <= 1'b1;
            end
            else
            begin
                ready_roll = $urandom_range(0, 99);
                if (ready_roll < 70)
                begin
                    hit_ready <= 1'b1;
                end
                else if (ready_roll < 95)
                begin
                    stall_left = $urandom_range(0, 2);
                    hit_ready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(9, 39);
                    hit_ready <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks result words, predicts accepted words, and runs the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hit_valid && hit_ready)
            begin
                hits_seen++;
                if (expected_hits.size() == 0)
                begin
                    $error("hit: unexpected word, actual %0b", hit);
                    error_count++;
                end
                else if (hit !== expected_hits[0])
                begin
                    $error("hit: expected %0b, actual %0b", expected_hits[0], hit);
                    error_count++;
                    void'(expected_hits.pop_front());
                end
                else
                begin
                    void'(expected_hits.pop_front());
                end
            end
            if (item_valid && item_ready)
            begin
                expected_hits.push_back(predict_hit(cmd, a_x, a_y, a_ext_x, a_ext_y,
                                                    b_x, b_y, b_ext_x, b_ext_y));
                pairs_accepted++;
            end
            in_accept <= item_valid && item_ready;
            if ((item_valid && item_ready) || (hit_valid && hit_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n = 1'b0;
        item_valid = 1'b0;
        hit_ready = 1'b0;
        cmd = '0;
        a_x = '0;
        a_y = '0;
        a_ext_x = '0;
        a_ext_y = '0;
        b_x = '0;
        b_y = '0;
        b_ext_x = '0;
        b_ext_y = '0;
        staged_ok = 1'b0;
        gap_left = 0;
        in_accept = 1'b0;
        pairs_accepted = 0;
        hits_seen = 0;
        error_count = 0;
        quiet_cycles = 0;
        stall_left = 0;
        long_hold_done = 1'b0;

        // Directed words: touching edges, exact radius distances, extremes, unused selectors.
        add_pair(ct2d_pkg::CMD_BOX_BOX, 0, 0, 256, 256, 256, 0, 256, 256, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_BOX, 0, 0, 256, 256, 257, 0, 10, 10, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_BOX, COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX,
                 COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX, 1, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_BOX, COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX,
                 -1, -1, 0, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_CIRCLE_CIRCLE, 0, 0, 300, 0, 300, 400, 200, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_CIRCLE_CIRCLE, 0, 0, 300, 0, 301, 400, 200, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_CIRCLE_CIRCLE, COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX,
                 COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX, 5, 1'b0);
        add_pair(ct2d_pkg::CMD_CIRCLE_CIRCLE, 5, 5, 0, 0, 5, 5, 0, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_CIRCLE, 0, 0, 100, 100, 103, 104, 5, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_CIRCLE, 0, 0, 100, 100, 103, 104, 4, 0, 1, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_CIRCLE, 0, 0, 100, 100, 50, 50, 0, EXT_MAX, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_BOX_CIRCLE, COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX,
                 COORD_MAX, COORD_MAX, EXT_MAX, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_CIRCLE_BOX, -3, -4, 5, 0, 0, 0, 100, 100, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_CIRCLE_BOX, -3, -4, 4, EXT_MAX, 0, 0, 100, 100, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_POINT_BOX, 100, 100, EXT_MAX, EXT_MAX,
                 0, 0, 100, 100, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_POINT_BOX, 101, 50, 0, 0, 0, 0, 100, 100, 1, 1'b0);
        add_pair(ct2d_pkg::CMD_POINT_BOX, COORD_MIN, COORD_MAX, 0, 0,
                 COORD_MIN, 0, 0, EXT_MAX, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_POINT_CIRCLE, 3, 4, 0, 0, 0, 0, 5, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_POINT_CIRCLE, 3, 4, 0, 0, 0, 0, 4, 0, 0, 1'b0);
        add_pair(ct2d_pkg::CMD_POINT_CIRCLE, COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX,
                 COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX, 0, 1'b0);
        add_pair(CMD_UNUSED_6, 0, 0, 256, 256, 0, 0, 256, 256, 0, 1'b0);
        add_pair(CMD_UNUSED_7, 0, 0, 256, 256, 0, 0, 256, 256, 0, 1'b1);

        for (i = 0; i < RANDOM_WORDS; i++)
            pending_pairs.push_back(random_pair(i));
        pairs_total = pending_pairs.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to be taken and every result to come back.
        while (pairs_accepted < pairs_total || expected_hits.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
